@@ hdl/rmsn_pkg.sv @@
// ----------------------------------------------------------------------------
// rmsn_pkg
// shared types and constants of the rms normalization forward unit
// ----------------------------------------------------------------------------
`default_nettype none

package rmsn_pkg;

  // command codes of the input channel
  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_EPSILON    = 1'b1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned EPS_W      = 32;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned ROOT_W     = 24;

  // running sum of squares wraps at this width
  localparam int unsigned SUM_W = 38;
  // mean square plus epsilon
  localparam int unsigned V_W   = 39;
  // 2^52 / v, wide enough for v == 1
  localparam int unsigned RECIP_W = 53;

  localparam logic [LEN_W-1:0]  ROW_LENGTH_RST = 7'd64;
  localparam logic [EPS_W-1:0]  EPSILON_RST    = 32'd17;
  localparam logic [ROOT_W-1:0] ROOT_MAX       = 24'hFFFFFF;

endpackage

`default_nettype wire

@@ hdl/rmsn_ram.sv @@
// ----------------------------------------------------------------------------
// rmsn_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rmsn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/rmsn_div.sv @@
// ----------------------------------------------------------------------------
// rmsn_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rmsn_div #(
  parameter int unsigned DW = 53,
  parameter int unsigned VW = 39
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    quo_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    den_r;
  logic             done_r;
  logic [VW:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? VW'(rem_sh - {1'b0, den_r}) : rem_sh[VW-1:0];
        quo_r <= {quo_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ hdl/rmsn_isqrt.sv @@
// ----------------------------------------------------------------------------
// rmsn_isqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rmsn_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [rmsn_pkg::RECIP_W-1:0]  radicand,
  output logic                               done,
  output logic      [rmsn_pkg::ROOT_W-1:0]   root
);

  localparam int unsigned XW    = rmsn_pkg::RECIP_W + 1;
  localparam int unsigned RW    = XW / 2;
  localparam int unsigned REMW  = RW + 3;
  localparam int unsigned CNT_W = $clog2(RW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [XW-1:0]    x_r;
  logic [RW-1:0]    root_r;
  logic [REMW-1:0]  rem_r;
  logic [REMW-1:0]  rem_sh;
  logic [REMW-1:0]  trial;
  logic             fits;

  assign rem_sh = {rem_r[REMW-3:0], x_r[XW-1:XW-2]};
  assign trial  = REMW'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RW);
        x_r    <= XW'(radicand);
        root_r <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? rem_sh - trial : rem_sh;
        root_r <= {root_r[RW-2:0], fits};
        x_r    <= {x_r[XW-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // saturate to unsigned 24 bits with 26 fraction bits
  assign done = done_r;
  assign root = (root_r > RW'(rmsn_pkg::ROOT_MAX)) ? rmsn_pkg::ROOT_MAX
                                                  : root_r[rmsn_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

@@ hdl/rms_norm_forward_unit.sv @@
// ----------------------------------------------------------------------------
// rms_norm_forward_unit
// rms normalization of one row at a time with per-column gain
// ----------------------------------------------------------------------------
//
//   channel | direction | transfer when      | payload
//   --------+-----------+--------------------+-----------------------------------
//   in_     | input     | in_valid & ready   | cmd, weight_index, weight_value,
//           |           |                    | sample
//   out_    | output    | out_valid & ready  | column, normalized, inverse_root,
//           |           |                    | end_of_row
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// a gain write or a sample that does not close its row leaves the input ready
// closing a row runs the shared divider for the mean, then for the reciprocal,
// then the square root unit; a zero mean square plus epsilon skips both and saturates the inverse root
// each result then passes memory read, two multiplies, rounding and the output
// register, and the next starts only once it is taken; an output stall holds
// the sequencer in place; the input is not ready while a row is being finished or emitted
// synchronous reset clears control state; both tables start undefined
// ----------------------------------------------------------------------------
`default_nettype none

module rms_norm_forward_unit #(
  parameter int unsigned MAX_HIDDEN   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_cmd,
  input  wire logic [rmsn_pkg::COL_W-1:0]          in_weight_index,
  input  wire logic signed [rmsn_pkg::GAIN_W-1:0]  in_weight_value,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [rmsn_pkg::COL_W-1:0]          out_column,
  output logic signed [rmsn_pkg::NORM_W-1:0]       out_normalized,
  output logic      [rmsn_pkg::ROOT_W-1:0]         out_inverse_root,
  output logic                                     out_end_of_row,
  // configuration port
  input  wire logic                                cfg_we,
  input  wire logic [rmsn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rmsn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned AW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int unsigned CW  = $clog2(MAX_HIDDEN + 1);
  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned PW1 = SW + rmsn_pkg::ROOT_W;
  localparam int unsigned PW2 = PW1 + rmsn_pkg::GAIN_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_INV,
    ST_ROOT,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_ROUND,
    ST_OUT
  } state_t;

  state_t                          state_r;
  logic [rmsn_pkg::LEN_W-1:0]      row_length_r;
  logic [rmsn_pkg::EPS_W-1:0]      epsilon_r;
  logic [rmsn_pkg::SUM_W-1:0]      sum_r;
  logic [CW-1:0]                   fill_r;
  logic [CW-1:0]                   k_r;
  logic [rmsn_pkg::V_W-1:0]        v_r;
  logic [rmsn_pkg::ROOT_W-1:0]     root_r;
  logic                            div_start_r;
  logic                            div_inv_r;
  logic                            sqrt_start_r;
  logic [PW1-1:0]                  prod1_r;
  logic [rmsn_pkg::GAIN_W-1:0]     mw_r;
  logic                            neg_r;
  logic [63:0]                     p_r;

  logic                            out_valid_r;
  logic [rmsn_pkg::COL_W-1:0]      out_column_r;
  logic [rmsn_pkg::NORM_W-1:0]     out_norm_r;
  logic                            out_eor_r;

  // row length clamped to 1..MAX_HIDDEN
  logic [CW-1:0]                   row_len;
  logic [CW-1:0]                   fill_nxt;
  logic                            in_xfer;
  logic                            gain_we;
  logic                            row_we;
  logic [AW-1:0]                   gain_waddr;
  logic [31:0]                     widx_ext;
  logic                            s_neg;
  logic [SW-1:0]                   s_mag;
  logic [2*SW-1:0]                 s_sq;

  logic [SW-1:0]                   row_rdata;
  logic [rmsn_pkg::GAIN_W-1:0]     gain_rdata;
  logic [AW-1:0]                   raddr;
  logic [SW-1:0]                   a_mag;
  logic [rmsn_pkg::GAIN_W-1:0]     w_mag;
  logic [PW2-1:0]                  p_full;
  logic [63:0]                     p_rnd;
  logic [35:0]                     q;
  logic                            res_neg;
  logic [rmsn_pkg::NORM_W-1:0]     res;

  logic                            div_done;
  logic [rmsn_pkg::RECIP_W-1:0]    div_quo;
  logic [rmsn_pkg::RECIP_W-1:0]    div_dividend;
  logic [rmsn_pkg::V_W-1:0]        div_divisor;
  logic [rmsn_pkg::V_W-1:0]        v_calc;
  logic                            sqrt_done;
  logic [rmsn_pkg::ROOT_W-1:0]     sqrt_root;
  logic                            last_col;

  always_comb begin
    if (row_length_r == '0) begin
      row_len = CW'(1);
    end else if (32'(row_length_r) > MAX_HIDDEN) begin
      row_len = CW'(MAX_HIDDEN);
    end else begin
      row_len = CW'(row_length_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign fill_nxt = fill_r + 1'b1;

  // gain writes beyond the table are dropped
  assign widx_ext   = 32'(in_weight_index);
  assign gain_waddr = AW'(widx_ext);
  assign gain_we    = in_xfer && (in_cmd == rmsn_pkg::CMD_WEIGHT) && (widx_ext < MAX_HIDDEN);
  assign row_we     = in_xfer && (in_cmd == rmsn_pkg::CMD_SAMPLE);

  // square of the sample through its magnitude
  assign s_neg = in_sample[SW-1];
  assign s_mag = s_neg ? SW'(-in_sample) : SW'(in_sample);
  assign s_sq  = (2*SW)'(s_mag) * (2*SW)'(s_mag);

  assign raddr = k_r[AW-1:0];

  rmsn_ram #(
    .WIDTH (rmsn_pkg::GAIN_W),
    .DEPTH (MAX_HIDDEN)
  ) u_gain_ram (
    .clk   (clk),
    .we    (gain_we),
    .waddr (gain_waddr),
    .wdata (in_weight_value),
    .raddr (raddr),
    .rdata (gain_rdata)
  );

  rmsn_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_HIDDEN)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_sample),
    .raddr (raddr),
    .rdata (row_rdata)
  );

  // one divider serves both the mean and the reciprocal 2^52 / v
  assign div_dividend = div_inv_r ? (rmsn_pkg::RECIP_W'(1) << 52)
                                  : rmsn_pkg::RECIP_W'(sum_r);
  assign div_divisor  = div_inv_r ? v_r : rmsn_pkg::V_W'(fill_r);

  rmsn_div #(
    .DW (rmsn_pkg::RECIP_W),
    .VW (rmsn_pkg::V_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  rmsn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start_r),
    .radicand (div_quo),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // mean fits in 38 bits, so v never wraps
  assign v_calc = div_quo[rmsn_pkg::V_W-1:0] + rmsn_pkg::V_W'(epsilon_r);

  // magnitudes of the stored sample and gain
  assign a_mag = row_rdata[SW-1] ? SW'(-row_rdata) : row_rdata;
  assign w_mag = gain_rdata[rmsn_pkg::GAIN_W-1] ? rmsn_pkg::GAIN_W'(-gain_rdata) : gain_rdata;

  assign p_full = PW2'(prod1_r) * PW2'(mw_r);

  // round half away from zero on the magnitude, then saturate to q4.12
  assign p_rnd   = p_r + (64'd1 << 27);
  assign q       = p_rnd[63:28];
  assign res_neg = neg_r && (q != '0);
  always_comb begin
    if (res_neg) begin
      res = (q >= 36'd32768) ? 16'h8000 : 16'(17'h10000 - 17'(q));
    end else begin
      res = (q > 36'd32767) ? 16'h7FFF : q[15:0];
    end
  end

  assign last_col = (k_r + 1'b1) == fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_length_r <= rmsn_pkg::ROW_LENGTH_RST;
      epsilon_r    <= rmsn_pkg::EPSILON_RST;
      sum_r        <= '0;
      fill_r       <= '0;
      k_r          <= '0;
      div_start_r  <= 1'b0;
      div_inv_r    <= 1'b0;
      sqrt_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          rmsn_pkg::REG_ROW_LENGTH: row_length_r <= cfg_wdata[rmsn_pkg::LEN_W-1:0];
          rmsn_pkg::REG_EPSILON:    epsilon_r    <= cfg_wdata[rmsn_pkg::EPS_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (row_we) begin
            sum_r  <= sum_r + rmsn_pkg::SUM_W'(s_sq);
            fill_r <= fill_nxt;
            // row closes when the count reaches the length in use
            if (fill_nxt >= row_len) begin
              div_inv_r   <= 1'b0;
              div_start_r <= 1'b1;
              state_r     <= ST_MEAN;
            end
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            v_r <= v_calc;
            k_r <= '0;
            if (v_calc == '0) begin
              root_r  <= rmsn_pkg::ROOT_MAX;
              state_r <= ST_READ;
            end else begin
              div_inv_r   <= 1'b1;
              div_start_r <= 1'b1;
              state_r     <= ST_INV;
            end
          end
        end
        ST_INV: begin
          if (div_done) begin
            sqrt_start_r <= 1'b1;
            state_r      <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            root_r  <= sqrt_root;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          prod1_r <= PW1'(a_mag) * PW1'(root_r);
          mw_r    <= w_mag;
          neg_r   <= row_rdata[SW-1] ^ gain_rdata[rmsn_pkg::GAIN_W-1];
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          p_r     <= 64'(p_full);
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          out_valid_r  <= 1'b1;
          out_column_r <= rmsn_pkg::COL_W'(k_r);
          out_norm_r   <= res;
          out_eor_r    <= last_col;
          state_r      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 1'b1;
            if (out_eor_r) begin
              sum_r   <= '0;
              fill_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column       = out_column_r;
  assign out_normalized   = out_norm_r;
  assign out_inverse_root = root_r;
  assign out_end_of_row   = out_eor_r;

endmodule

`default_nettype wire

@@ hdl/rmsn_checker.sv @@
// ----------------------------------------------------------------------------
// rmsn_checker
// port-level checks of the rms normalization forward unit
// ----------------------------------------------------------------------------
`default_nettype none

module rmsn_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [rmsn_pkg::NORM_W-1:0]       out_normalized,
  input wire logic [rmsn_pkg::ROOT_W-1:0]       out_inverse_root,
  input wire logic                              out_end_of_row
);

  // a result never coexists with an open input
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // mid-row transfer keeps the input closed
  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_end_of_row) |=> !in_ready)
    else $error("input reopened before end of row");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_normalized) && $stable(out_inverse_root)))
    else $error("result changed under stall");

  // nothing presented right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind rms_norm_forward_unit rmsn_checker u_rmsn_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_normalized   (out_normalized),
  .out_inverse_root (out_inverse_root),
  .out_end_of_row   (out_end_of_row)
);

`default_nettype wire
